// ----- hdl/sha1_pkg.sv -----
// shared types, constants and round functions for the sha-1 hasher
`default_nettype none

package sha1_pkg;

  localparam int SHA1_QUEUE_DEPTH = 4;

  // item codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } sha1_item_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_PADZ,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha1_state_t;

  function automatic logic [1:0] sha1_phase(input logic [6:0] round);
    logic [1:0] ph;
    if (round < 7'd20) begin
      ph = 2'd0;
    end else if (round < 7'd40) begin
      ph = 2'd1;
    end else if (round < 7'd60) begin
      ph = 2'd2;
    end else begin
      ph = 2'd3;
    end
    return ph;
  endfunction

  function automatic logic [31:0] sha1_f(input logic [1:0] ph, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (ph)
      2'd0: f = (b & c) | (~b & d);
      2'd2: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] sha1_k(input logic [1:0] ph);
    logic [31:0] k;
    case (ph)
      2'd0: k = 32'h5a827999;
      2'd1: k = 32'h6ed9eba1;
      2'd2: k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sha1_message_hasher.sv -----
// top level of the streaming sha-1 hasher: input queue plus hash engine
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_action, in_data_byte
//  out_    | output    | out_valid / out_ready | out_digest_word, out_word_index, out_last_word
//
// the engine takes one queued byte per cycle while fetching; a full 64-byte block then
// holds the queue for the single-round compression loop (80 rounds plus the final add).
// a finish item pads one byte per cycle, runs one or two compressions and
// then shows one digest word per cycle while out_ready stays high.
// synchronous active-low reset restores the initial hash value and empties the queue.
// the queue takes up to four items while the engine compresses or the output stalls.
`default_nettype none

module sha1_message_hasher #(
  parameter int QUEUE_DEPTH = sha1_pkg::SHA1_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1_pkg::*;

  logic       q_valid;
  sha1_item_t q_item;
  logic       q_pop;

  sha1_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  sha1_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

// ----- hdl/sha1_front.sv -----
// input side: accepts items into a short queue ahead of the hash engine
`default_nettype none

module sha1_front #(
  parameter int QUEUE_DEPTH = sha1_pkg::SHA1_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [7:0]           in_data_byte,
  output logic                      q_valid,
  output sha1_pkg::sha1_item_t      q_item,
  input  wire logic                 q_pop
);
  import sha1_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sha1_item_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{action: in_action, data_byte: in_data_byte};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sha1_core.sv -----
// hash engine: block buffer, padding sequencer, 80-round compression, digest output
`default_nettype none

module sha1_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire sha1_pkg::sha1_item_t q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_digest_word,
  output logic [2:0]                out_word_index,
  output logic                      out_last_word
);
  import sha1_pkg::*;

  sha1_state_t state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;          // message length in bytes
  logic [5:0]  pos_r, pos_nxt;
  logic        pad_r, pad_nxt;
  logic        extra_r, extra_nxt;      // padding spills into a second block
  logic        lendone_r, lendone_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        start;
  logic [63:0] len_bits;
  logic [63:0] len_shift;
  logic [1:0]  phase;
  logic [31:0] t_sum;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  assign len_bits  = {cnt_r, 3'b000};
  // byte 56 carries the most significant length byte
  assign len_shift = len_bits >> {~pos_r[2:0], 3'b000};
  assign phase     = sha1_phase(round_r);
  assign t_sum     = {a_r[26:0], a_r[31:27]} + sha1_f(phase, b_r, c_r, d_r) + e_r
                     + sha1_k(phase) + w_r[0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    pad_nxt       = pad_r;
    extra_nxt     = extra_r;
    lendone_nxt   = lendone_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_byte       = '0;
    start         = 1'b0;

    case (state_r)
      ST_FETCH: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          wr_en   = 1'b1;
          pos_nxt = pos_r + 6'd1;
          if (q_item.action == ACT_ABSORB) begin
            wr_byte = q_item.data_byte;
            cnt_nxt = cnt_r + 61'd1;
          end else begin
            wr_byte   = PAD_BYTE;
            pad_nxt   = 1'b1;
            extra_nxt = (pos_r >= LEN_POS) && (pos_r != LAST_POS);
          end
          if (pos_r == LAST_POS) begin
            start = 1'b1;
          end else if (q_item.action == ACT_FINISH) begin
            state_nxt = ST_PADZ;
          end
        end
      end
      ST_PADZ: begin
        if (pos_r == LEN_POS && !extra_r) begin
          state_nxt = ST_LEN;
        end else begin
          wr_en   = 1'b1;
          wr_byte = '0;
          pos_nxt = pos_r + 6'd1;
          if (pos_r == LAST_POS) begin
            extra_nxt = 1'b0;
            start     = 1'b1;
          end
        end
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = len_shift[7:0];
        pos_nxt = pos_r + 6'd1;
        if (pos_r == LAST_POS) begin
          lendone_nxt = 1'b1;
          start       = 1'b1;
        end
      end
      ST_ROUND: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        b_nxt = a_r;
        a_nxt = t_sum;
        // message schedule slides one word per round
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
        w_nxt[15] = {w_nxt[15][30:0], w_nxt[15][31]};
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (lendone_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PADZ;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = h_r[idx_r];
          out_idx_nxt   = idx_r;
          out_last_nxt  = (idx_r == LAST_WORD_IDX);
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == LAST_WORD_IDX) begin
            // back to the initial value for the next message
            h_nxt       = SHA1_IV;
            cnt_nxt     = '0;
            pos_nxt     = '0;
            pad_nxt     = 1'b0;
            extra_nxt   = 1'b0;
            lendone_nxt = 1'b0;
            state_nxt   = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_FETCH;
      end
    endcase

    if (wr_en) begin
      case (pos_r[1:0])
        2'd0: w_nxt[pos_r[5:2]][31:24] = wr_byte;
        2'd1: w_nxt[pos_r[5:2]][23:16] = wr_byte;
        2'd2: w_nxt[pos_r[5:2]][15:8]  = wr_byte;
        default: w_nxt[pos_r[5:2]][7:0] = wr_byte;
      endcase
    end

    if (start) begin
      a_nxt     = h_r[0];
      b_nxt     = h_r[1];
      c_nxt     = h_r[2];
      d_nxt     = h_r[3];
      e_nxt     = h_r[4];
      round_nxt = '0;
      state_nxt = ST_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      cnt_r       <= '0;
      pos_r       <= '0;
      pad_r       <= 1'b0;
      extra_r     <= 1'b0;
      lendone_r   <= 1'b0;
      round_r     <= '0;
      idx_r       <= '0;
      h_r         <= SHA1_IV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      pad_r       <= pad_nxt;
      extra_r     <= extra_nxt;
      lendone_r   <= lendone_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    w_r        <= w_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/sha1_checker.sv -----
// port-level checks for the sha-1 hasher and their binding to the top level
`default_nettype none

module sha1_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index) && $stable(out_last_word))
    else $error("result changed while stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last_word does not match word index");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index <= 3'd4))
    else $error("word index out of range");

  // digest words leave in order with no gaps
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_word_index != 3'd4) |=>
      !out_valid || (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word skipped or repeated");

  // handshake outputs are always known out of reset
  a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_ready) && !$isunknown(out_valid))
    else $error("in_ready or out_valid unknown");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (.*);

`default_nettype wire

// ----- tb/sv/sha1_message_hasher_test.sv -----
// self-checking testbench for the streaming sha-1 message hasher
module sha1_message_hasher_test;
  import sha1_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 65;

  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_PAR = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_END = 32'hca62c1d6;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_action = ACT_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // predictor state
  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  logic [63:0] bit_count;

  digest_word_t pending_words [$];
  digest_word_t expected_word;
  int           err_count = 0;
  int           sent_items = 0;
  int           quiet_cycles = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;

  sha1_message_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void hash_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    end
    for (r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_END;
      end
      t = {a[26:0], a[31:27]} + f + e + w[r] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void clear_hash_state();
    chain = SHA1_IV;
    foreach (blk[i]) blk[i] = 8'h00;
    bit_count = '0;
  endfunction

  function automatic void predict_digest(input logic act, input logic [7:0] data);
    int p;
    int i;
    digest_word_t dw;
    p = int'(bit_count[8:3]);
    if (act == ACT_ABSORB) begin
      blk[p] = data;
      bit_count += 64'd8;
      if (p == 63) hash_block();
    end else begin
      blk[p] = PAD_BYTE;
      p++;
      // length field does not fit, pad out this block first
      if (p > 56) begin
        for (i = p; i < 64; i++) blk[i] = 8'h00;
        hash_block();
        p = 0;
      end
      for (i = p; i < 56; i++) blk[i] = 8'h00;
      for (i = 0; i < 8; i++) blk[56+i] = bit_count[63-8*i -: 8];
      hash_block();
      for (i = 0; i < 5; i++) begin
        dw.word = chain[i];
        dw.idx  = 3'(i);
        dw.last = (i == 4);
        pending_words.push_back(dw);
      end
      clear_hash_state();
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $time, field, got, want);
    err_count++;
  endtask

  task automatic send_item(input logic act, input logic [7:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    predict_digest(act, data);
    sent_items++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(ACT_ABSORB, 8'($urandom));
    send_item(ACT_FINISH, 8'($urandom));
  endtask

  task automatic test_short_messages();
    idle_on = 1'b1;
    send_item(ACT_FINISH, 8'h00);  // empty message
    send_item(ACT_FINISH, 8'hff);  // empty again, byte must be ignored
    send_item(ACT_ABSORB, 8'h61);
    send_item(ACT_ABSORB, 8'h62);
    send_item(ACT_ABSORB, 8'h63);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_ABSORB, 8'h00);
    send_item(ACT_ABSORB, 8'hff);
    send_item(ACT_FINISH, 8'h5a);
    send_item(ACT_ABSORB, 8'hff);
    send_item(ACT_FINISH, 8'ha5);
    send_item(ACT_ABSORB, 8'h80);
    send_item(ACT_FINISH, 8'hff);
  endtask

  task automatic test_random_messages();
    int start_count;
    int n_msg;
    int len;
    start_count = sent_items;
    n_msg = 0;
    while (sent_items - start_count < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      // first message forces two-block padding
      if (n_msg == 0) len = $urandom_range(56, 63);
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(52, 70);
      else len = $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        // occasional finish in the middle of a message
        if ($urandom_range(0, 15) == 0) send_item(ACT_FINISH, 8'($urandom));
        send_item(ACT_ABSORB, 8'($urandom));
      end
      send_item(ACT_FINISH, 8'($urandom));
      n_msg++;
    end
  endtask

  task automatic test_full_rate_stream();
    idle_on = 1'b0;
    send_message(64);
    send_message(0);
    send_message($urandom_range(1, 8));
  endtask

  // result side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected digest word", out_digest_word, 32'h0);
      end else begin
        expected_word = pending_words.pop_front();
        if (out_digest_word !== expected_word.word)
          report_mismatch("digest_word", out_digest_word, expected_word.word);
        if (out_word_index !== expected_word.idx)
          report_mismatch("word_index", 32'(out_word_index), 32'(expected_word.idx));
        if (out_last_word !== expected_word.last)
          report_mismatch("last_word", 32'(out_last_word), 32'(expected_word.last));
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_hash_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_messages();
    test_random_messages();
    test_full_rate_stream();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_core.sv
hdl/sha1_message_hasher.sv
hdl/sha1_checker.sv
tb/sv/sha1_message_hasher_test.sv
